### rtl/core/pairwise_gravity_force_accumulator_unit_macros.svh
// assertion macros used by pgfa_core
`ifndef PAIRWISE_GRAVITY_FORCE_ACCUMULATOR_UNIT_MACROS_SVH
`define PAIRWISE_GRAVITY_FORCE_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent in one cycle implies consequent in the next
`define PGFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgfa check failed");

// condition must never hold
`define PGFA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pgfa check failed");

`else

`define PGFA_ASSERT_NEXT(lbl, ante, cons)
`define PGFA_ASSERT_NEVER(lbl, cond)

`endif

`endif

### rtl/core/pgfa_pkg.sv
package pgfa_pkg;

    // field widths
    localparam int CW   = 32;
    localparam int MW   = 32;
    localparam int SW   = 48;
    localparam int G_W  = 32;
    localparam int SH_W = 6;

    // derived datapath widths
    localparam int AD_W      = CW + 1;
    localparam int RT_W      = CW + 2;
    localparam int SQ_W      = 2 * RT_W;
    localparam int DEN_W     = 3 * RT_W;
    localparam int K_W       = G_W + 2 * MW;
    localparam int Q_W       = SW + 2;
    localparam int ACC_W     = DEN_W + Q_W;
    localparam int MUL_STEPS = RT_W;
    localparam int CNT_W     = $clog2(Q_W + 1);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_SHIFT   = 1'b1;

    typedef struct packed {
        logic [G_W-1:0]  gravity_constant;
        logic [SH_W-1:0] scale_shift;
    } cfg_t;

endpackage

### rtl/core/pgfa_in_if.sv
interface pgfa_in_if import pgfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] self_x;
    logic signed [CW-1:0] self_y;
    logic signed [CW-1:0] self_z;
    logic signed [CW-1:0] other_x;
    logic signed [CW-1:0] other_y;
    logic signed [CW-1:0] other_z;
    logic [MW-1:0]        self_mass;
    logic [MW-1:0]        other_mass;
    logic                 start_sum;

    modport source (
        output valid, self_x, self_y, self_z, other_x, other_y, other_z,
               self_mass, other_mass, start_sum,
        input  ready
    );
    modport sink (
        input  valid, self_x, self_y, self_z, other_x, other_y, other_z,
               self_mass, other_mass, start_sum,
        output ready
    );
endinterface

### rtl/core/pgfa_out_if.sv
interface pgfa_out_if import pgfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] force_x;
    logic signed [SW-1:0] force_y;
    logic signed [SW-1:0] force_z;
    logic                 coincident;

    modport source (
        output valid, force_x, force_y, force_z, coincident,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, coincident,
        output ready
    );
endinterface

### rtl/core/pgfa_cfg.sv
module pgfa_cfg import pgfa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [G_W-1:0]  gravity_reg;
    logic [SH_W-1:0] shift_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= G_W'(1);
            shift_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_GRAVITY)
                gravity_reg <= pwdata[G_W-1:0];
            else
                shift_reg <= pwdata[SH_W-1:0];
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_SHIFT) ? DATA_W'(shift_reg) : DATA_W'(gravity_reg);

    assign cfg.gravity_constant = gravity_reg;
    assign cfg.scale_shift      = shift_reg;

endmodule

### rtl/core/pgfa_core.sv
`include "pairwise_gravity_force_accumulator_unit_macros.svh"

module pgfa_core import pgfa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    pgfa_in_if.sink    item,
    pgfa_out_if.source result
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_R2   = 4'd3;
    localparam logic [3:0] ST_R3   = 4'd4;
    localparam logic [3:0] ST_K1   = 4'd5;
    localparam logic [3:0] ST_K2   = 4'd6;
    localparam logic [3:0] ST_KSH  = 4'd7;
    localparam logic [3:0] ST_NUM  = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_ACC  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(RT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           axis_reg, axis_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     mcand_reg, mcand_next;
    logic [RT_W-1:0]      mplier_reg, mplier_next;
    logic [RT_W-1:0]      root_reg, root_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [MW-1:0]        m1_reg, m1_next;
    logic [MW-1:0]        m2_reg, m2_next;
    logic [AD_W-1:0]      ad_reg [3];
    logic [AD_W-1:0]      ad_next [3];
    logic [2:0]           neg_reg, neg_next;
    logic                 coinc_reg, coinc_next;
    logic signed [SW-1:0] force_reg [3];
    logic signed [SW-1:0] force_next [3];

    logic [AD_W:0]        dx, dy, dz;
    logic                 coinc_in;
    logic                 accept;
    logic [ACC_W-1:0]     remsh, trial, alu_a, alu_b;
    logic                 alu_sub;
    logic [ACC_W:0]       alu_res;
    logic                 alu_ge;
    logic [ACC_W-1:0]     mul_acc;
    logic [RT_W-1:0]      root_new;
    logic [K_W-1:0]       k_shifted;
    logic [SW:0]          q_sat;
    logic [SW+1:0]        sum_ext, q_ext, sum_t;
    logic signed [SW-1:0] sum_cur, sum_new;

    // sign and magnitude of a coordinate difference
    function automatic logic [AD_W:0] diff_mag(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
        logic signed [AD_W-1:0] d;
        logic [AD_W-1:0]        m;
        d = AD_W'(a) - AD_W'(b);
        m = d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
        return {d[AD_W-1], m};
    endfunction

    assign dx       = diff_mag(item.self_x, item.other_x);
    assign dy       = diff_mag(item.self_y, item.other_y);
    assign dz       = diff_mag(item.self_z, item.other_z);
    assign coinc_in = (dx[AD_W-1:0] | dy[AD_W-1:0] | dz[AD_W-1:0]) == '0;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid & item.ready;

    // shared add / subtract unit
    assign remsh   = {acc_reg[ACC_W-3:0], mcand_reg[ACC_W-1 -: 2]};
    assign trial   = ACC_W'({root_reg, 2'b01});
    assign alu_a   = (state_reg == ST_SQRT) ? remsh : acc_reg;
    assign alu_b   = (state_reg == ST_SQRT) ? trial : mcand_reg;
    assign alu_sub = (state_reg == ST_SQRT) || (state_reg == ST_DIV);
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ACC_W+1)'(alu_sub);
    assign alu_ge  = alu_res[ACC_W];
    assign mul_acc = mplier_reg[0] ? alu_res[ACC_W-1:0] : acc_reg;

    assign root_new  = {root_reg[RT_W-2:0], alu_ge};
    assign k_shifted = acc_reg[K_W-1:0] >> cfg.scale_shift;

    // saturating update of one force sum
    assign q_sat   = (q_reg[Q_W-1:SW] != '0) ? {1'b1, {SW{1'b0}}} : {1'b0, q_reg[SW-1:0]};
    assign sum_cur = force_reg[axis_reg];
    assign sum_ext = {{2{sum_cur[SW-1]}}, sum_cur};
    assign q_ext   = {1'b0, q_sat};
    assign sum_t   = neg_reg[0] ? (sum_ext + q_ext) : (sum_ext - q_ext);
    always_comb
    begin
        if ((sum_t[SW+1:SW-1] == 3'b000) || (sum_t[SW+1:SW-1] == 3'b111))
            sum_new = sum_t[SW-1:0];
        else if (sum_t[SW+1])
            sum_new = SUM_MIN;
        else
            sum_new = SUM_MAX;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        root_next   = root_reg;
        den_next    = den_reg;
        k_next      = k_reg;
        q_next      = q_reg;
        m1_next     = m1_reg;
        m2_next     = m2_reg;
        neg_next    = neg_reg;
        coinc_next  = coinc_reg;
        for (int i = 0; i < 3; i++)
        begin
            ad_next[i]    = ad_reg[i];
            force_next[i] = force_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ad_next[0]  = dx[AD_W-1:0];
                    ad_next[1]  = dy[AD_W-1:0];
                    ad_next[2]  = dz[AD_W-1:0];
                    neg_next    = {dz[AD_W], dy[AD_W], dx[AD_W]};
                    m1_next     = item.self_mass;
                    m2_next     = item.other_mass;
                    coinc_next  = coinc_in;
                    if (item.start_sum)
                    begin
                        for (int i = 0; i < 3; i++)
                            force_next[i] = '0;
                    end
                    acc_next    = '0;
                    mcand_next  = ACC_W'(dx[AD_W-1:0]);
                    mplier_next = RT_W'(dx[AD_W-1:0]);
                    cnt_next    = MUL_LAST;
                    axis_next   = 2'd0;
                    state_next  = coinc_in ? ST_OUT : ST_SQ;
                end
            end

            ST_SQ:
            begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // rotate so the next axis sits in place zero
                    ad_next[0] = ad_reg[1];
                    ad_next[1] = ad_reg[2];
                    ad_next[2] = ad_reg[0];
                    neg_next   = {neg_reg[0], neg_reg[2:1]};
                    if (axis_reg == 2'd2)
                    begin
                        acc_next   = '0;
                        mcand_next = {mul_acc[SQ_W-1:0], {(ACC_W-SQ_W){1'b0}}};
                        root_next  = '0;
                        cnt_next   = SQRT_LAST;
                        axis_next  = 2'd0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        mcand_next  = ACC_W'(ad_reg[1]);
                        mplier_next = RT_W'(ad_reg[1]);
                        cnt_next    = MUL_LAST;
                        axis_next   = axis_reg + 1'b1;
                    end
                end
            end

            ST_SQRT:
            begin
                acc_next   = alu_ge ? alu_res[ACC_W-1:0] : remsh;
                root_next  = root_new;
                mcand_next = mcand_reg << 2;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(root_new);
                    mplier_next = root_new;
                    cnt_next    = MUL_LAST;
                    state_next  = ST_R2;
                end
            end

            ST_R2, ST_R3, ST_K1, ST_K2:
            begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    mcand_next = mul_acc;
                    cnt_next   = MUL_LAST;
                    case (state_reg)
                        ST_R2:
                        begin
                            mplier_next = root_reg;
                            state_next  = ST_R3;
                        end
                        ST_R3:
                        begin
                            den_next    = mul_acc[DEN_W-1:0];
                            mcand_next  = ACC_W'(cfg.gravity_constant);
                            mplier_next = RT_W'(m1_reg);
                            state_next  = ST_K1;
                        end
                        ST_K1:
                        begin
                            mplier_next = RT_W'(m2_reg);
                            state_next  = ST_K2;
                        end
                        default:
                        begin
                            acc_next   = mul_acc;
                            state_next = ST_KSH;
                        end
                    endcase
                end
            end

            ST_KSH:
            begin
                k_next      = k_shifted;
                acc_next    = '0;
                mcand_next  = ACC_W'(k_shifted);
                mplier_next = RT_W'(ad_reg[0]);
                cnt_next    = MUL_LAST;
                axis_next   = 2'd0;
                state_next  = ST_NUM;
            end

            ST_NUM:
            begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mcand_next = ACC_W'(den_reg) << (Q_W - 1);
                    q_next     = '0;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (alu_ge)
                    acc_next = alu_res[ACC_W-1:0];
                q_next     = {q_reg[Q_W-2:0], alu_ge};
                mcand_next = mcand_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_ACC;
            end

            ST_ACC:
            begin
                force_next[axis_reg] = sum_new;
                ad_next[0] = ad_reg[1];
                ad_next[1] = ad_reg[2];
                ad_next[2] = ad_reg[0];
                neg_next   = {neg_reg[0], neg_reg[2:1]};
                if (axis_reg == 2'd2)
                    state_next = ST_OUT;
                else
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(k_reg);
                    mplier_next = RT_W'(ad_reg[1]);
                    cnt_next    = MUL_LAST;
                    axis_next   = axis_reg + 1'b1;
                    state_next  = ST_NUM;
                end
            end

            ST_OUT:
            begin
                if (result.ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and sum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 2'd0;
            for (int i = 0; i < 3; i++)
                force_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            for (int i = 0; i < 3; i++)
                force_reg[i] <= force_next[i];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        root_reg   <= root_next;
        den_reg    <= den_next;
        k_reg      <= k_next;
        q_reg      <= q_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        neg_reg    <= neg_next;
        coinc_reg  <= coinc_next;
        for (int i = 0; i < 3; i++)
            ad_reg[i] <= ad_next[i];
    end

    // result word
    assign result.valid      = (state_reg == ST_OUT);
    assign result.force_x    = force_reg[0];
    assign result.force_y    = force_reg[1];
    assign result.force_z    = force_reg[2];
    assign result.coincident = coinc_reg;

    // checks
    `PGFA_ASSERT_NEVER(a_ready_while_result, item.ready && result.valid)
    `PGFA_ASSERT_NEXT(a_coincident_direct, accept && coinc_in, result.valid && coinc_reg)
    `PGFA_ASSERT_NEXT(a_div_to_acc, state_reg == ST_DIV && cnt_reg == '0, state_reg == ST_ACC)

endmodule

### rtl/core/pairwise_gravity_force_accumulator_unit.sv
// Pairwise gravity force accumulator: each input word carries two bodies' positions and
// masses; the block adds -((G*m1*m2) >> shift) * d / |d|^3 per axis to three saturating
// 48-bit force sums and returns the running sums in one result word. start_sum clears the
// sums first. A pair with equal positions adds nothing and goes from idle straight to the
// result state with coincident set. Any other pair runs on one 152-bit add/subtract
// unit that retires one multiplier bit, one root bit or one quotient bit per cycle:
// 3 squares, the square root, r^3 and G*m1*m2 (two multiplies each), the scale shift,
// then per axis a multiply, a divide and an update of the force sum.
// One pair is in flight at a time; input ready is low until the result word is taken.
module pairwise_gravity_force_accumulator_unit import pgfa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    pgfa_in_if.sink           item,
    pgfa_out_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    // configuration registers
    pgfa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // force computation
    pgfa_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule
